### sv/ffa_pkg.sv
package ffa_pkg;

  // Arena geometry and table depth.
  localparam int ARENA_BYTES  = 256;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_BLOCKS   = 16;

  // Offsets and sizes are carried in 8 bits, like the ports.
  localparam int AW = 8;

  localparam logic [AW-1:0] HDR       = AW'(HEADER_BYTES);
  localparam logic [AW-1:0] SPLIT_MIN = AW'(2 * HEADER_BYTES);
  localparam logic [AW-1:0] HEAD_SIZE = AW'(ARENA_BYTES - HEADER_BYTES);

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_GRANTED = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FREED   = 2'd2,
    ST_BADOFF  = 2'd3
  } status_t;

  // One table entry as held by a cell.
  typedef struct packed {
    logic          valid;
    logic          free;
    logic [AW-1:0] start;
    logic [AW-1:0] size;
  } entry_t;

  // Request that walks down the row of cells.
  typedef struct packed {
    logic          valid;
    op_t           op;
    logic [AW-1:0] req;
    logic [AW-1:0] off;
  } token_t;

  typedef enum logic [2:0] {
    CMD_HOLD        = 3'd0,
    CMD_WRITE       = 3'd1,
    CMD_FROM_LEFT   = 3'd2,
    CMD_FROM_RIGHT  = 3'd3,
    CMD_FROM_RIGHT2 = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    entry_t    wr;
  } cell_ctl_t;

  typedef struct packed {
    logic has_tok;
    logic hit;
    logic stop;
  } probe_t;

endpackage

### sv/ffa_cell.sv
module ffa_cell import ffa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  entry_t    init,
  input  logic      is_last,
  input  cell_ctl_t ctl,
  input  entry_t    left,
  input  entry_t    right1,
  input  entry_t    right2,
  input  token_t    tok_in,
  input  logic      tok_adv,
  input  logic      tok_clear,
  output entry_t    ent,
  output token_t    tok,
  output probe_t    probe
);

  logic match;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= init;
    end else begin
      unique case (ctl.cmd)
        CMD_HOLD:        ent <= ent;
        CMD_WRITE:       ent <= ctl.wr;
        CMD_FROM_LEFT:   ent <= left;
        CMD_FROM_RIGHT:  ent <= right1;
        CMD_FROM_RIGHT2: ent <= right2;
        default:         ent <= ent;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else if (tok_clear) begin
      tok.valid <= 1'b0;
    end else if (tok_adv) begin
      tok <= tok_in;
    end
  end

  // An allocation matches the first free entry that is large enough; a
  // release matches the entry whose payload starts at the given offset.
  always_comb begin
    if (tok.op == OP_ALLOC) begin
      match = ent.free && (ent.size >= tok.req);
    end else begin
      match = (AW'(ent.start + HDR) == tok.off);
    end
    probe.has_tok = tok.valid;
    probe.hit     = tok.valid && ent.valid && match;
    probe.stop    = tok.valid && !(ent.valid && match) && (!ent.valid || is_last);
  end

endmodule

### sv/first_fit_block_allocator_top.sv
// First-fit block allocator over a row of MAX_BLOCKS table cells.
// A request whose search finds a match rewrites the table in the update state before it strobes
// done; a failed search strobes done straight from the search state. The search walks one cell a cycle.
// One transaction is handled at a time: a new request is accepted only while busy is low.
// Reset (rst, synchronous) leaves one free block of ARENA_BYTES-HEADER_BYTES payload bytes.
// Results are strobed for one cycle on done; the receiver cannot stall them.
module first_fit_block_allocator_top import ffa_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic          operation,
  input  logic [AW-1:0] request_size,
  input  logic [AW-1:0] release_offset,
  output logic          done,
  output logic [1:0]    status,
  output logic [AW-1:0] payload_offset
);

  // The controller walks a request token along the cells, then, on a match,
  // rewrites the table around the matching entry in the update state.
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_UPDATE = 3'b100
  } state_t;

  state_t state;

  // Request fields kept for the update cycle.
  op_t           op_q;
  logic [AW-1:0] req_q;

  // hit_q marks the matching cell; passed_q marks the cells the token left
  // behind without a match. Cells with neither bit lie beyond the match.
  logic [MAX_BLOCKS-1:0] hit_q;
  logic [MAX_BLOCKS-1:0] passed_q;

  entry_t    ent    [MAX_BLOCKS];
  token_t    tok    [MAX_BLOCKS];
  probe_t    probe  [MAX_BLOCKS];
  cell_ctl_t ctl    [MAX_BLOCKS];
  entry_t    init_e [MAX_BLOCKS];
  entry_t    left_e [MAX_BLOCKS];
  entry_t    r1_e   [MAX_BLOCKS];
  entry_t    r2_e   [MAX_BLOCKS];
  token_t    tok_in [MAX_BLOCKS];

  logic [MAX_BLOCKS-1:0] hit_vec;
  logic [MAX_BLOCKS-1:0] stop_vec;
  logic [MAX_BLOCKS-1:0] tok_vec;
  logic [MAX_BLOCKS-1:0] valid_vec;
  logic [MAX_BLOCKS-1:0] hit_lo;   // cell j sees a match at j-1
  logic [MAX_BLOCKS-1:0] hit_hi;   // cell j sees a match at j+1
  logic [MAX_BLOCKS-1:0] after;    // cell j lies beyond the match

  logic   accept;
  logic   any_hit;
  logic   any_stop;
  token_t new_tok;

  // Entries around the match, picked by one-hot selection.
  entry_t ek;
  entry_t ep;
  entry_t en;

  logic [AW-1:0] diff;
  logic          split;
  logic          merge_next;
  logic          merge_prev;
  logic [AW-1:0] merged;
  entry_t        wr_alloc;
  entry_t        wr_split;
  entry_t        wr_free;
  entry_t        wr_prev;

  localparam logic [MAX_BLOCKS-1:0] ONE_V = MAX_BLOCKS'(1);

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    new_tok.valid = accept;
    new_tok.op    = op_t'(operation);
    new_tok.req   = request_size;
    new_tok.off   = release_offset;
  end

  // Row of cells. Each cell hands its token to the right neighbor every
  // cycle until a cell ends the search, and can load its entry from either side when the table shifts.
  for (genvar j = 0; j < MAX_BLOCKS; j++) begin : g_cell
    if (j == 0) begin : g_first
      always_comb begin
        init_e[j].valid = 1'b1;
        init_e[j].free  = 1'b1;
        init_e[j].start = '0;
        init_e[j].size  = HEAD_SIZE;
      end
      assign left_e[j] = '0;
      assign tok_in[j] = new_tok;
    end else begin : g_rest
      assign init_e[j] = '0;
      assign left_e[j] = ent[j-1];
      assign tok_in[j] = tok[j-1];
    end

    if (j + 1 < MAX_BLOCKS) begin : g_r1
      assign r1_e[j] = ent[j+1];
    end else begin : g_r1_end
      assign r1_e[j] = '0;
    end

    if (j + 2 < MAX_BLOCKS) begin : g_r2
      assign r2_e[j] = ent[j+2];
    end else begin : g_r2_end
      assign r2_e[j] = '0;
    end

    ffa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .init      (init_e[j]),
      .is_last   (j == MAX_BLOCKS - 1),
      .ctl       (ctl[j]),
      .left      (left_e[j]),
      .right1    (r1_e[j]),
      .right2    (r2_e[j]),
      .tok_in    (tok_in[j]),
      .tok_adv   (!(any_hit || any_stop)),
      .tok_clear (any_hit || any_stop),
      .ent       (ent[j]),
      .tok       (tok[j]),
      .probe     (probe[j])
    );

    assign hit_vec[j]   = probe[j].hit;
    assign stop_vec[j]  = probe[j].stop;
    assign tok_vec[j]   = probe[j].has_tok;
    assign valid_vec[j] = ent[j].valid;
  end

  assign any_hit  = |hit_vec;
  assign any_stop = |stop_vec;
  assign hit_lo   = hit_q << 1;
  assign hit_hi   = hit_q >> 1;
  assign after    = ~(passed_q | hit_q);

  always_comb begin
    ek = '0;
    ep = '0;
    en = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      ek = ek | (hit_q[i]  ? ent[i] : '0);
      ep = ep | (hit_hi[i] ? ent[i] : '0);
      en = en | (hit_lo[i] ? ent[i] : '0);
    end
  end

  // Allocation: the remainder is split off only when it leaves more than a
  // header of payload after its own header, and only if the table has room.
  always_comb begin
    diff  = ek.size - req_q;
    split = (diff > SPLIT_MIN) && !valid_vec[MAX_BLOCKS-1];

    wr_alloc.valid = 1'b1;
    wr_alloc.free  = 1'b0;
    wr_alloc.start = ek.start;
    wr_alloc.size  = split ? req_q : ek.size;

    wr_split.valid = 1'b1;
    wr_split.free  = 1'b1;
    wr_split.start = ek.start + HDR + req_q;
    wr_split.size  = diff - HDR;
  end

  // Release: fold the next block in first, then fold the result into the
  // previous block. Both merges land in one table rewrite.
  always_comb begin
    merge_next = en.valid && en.free;
    merge_prev = !hit_q[0] && ep.free;
    merged     = merge_next ? AW'(ek.size + en.size + HDR) : ek.size;

    wr_free.valid = 1'b1;
    wr_free.free  = 1'b1;
    wr_free.start = ek.start;
    wr_free.size  = merged;

    wr_prev.valid = 1'b1;
    wr_prev.free  = 1'b1;
    wr_prev.start = ep.start;
    wr_prev.size  = ep.size + merged + HDR;
  end

  always_comb begin
    for (int j = 0; j < MAX_BLOCKS; j++) begin
      ctl[j].cmd = CMD_HOLD;
      ctl[j].wr  = wr_alloc;
      if (state == S_UPDATE) begin
        if (op_q == OP_ALLOC) begin
          if (hit_q[j]) begin
            ctl[j].cmd = CMD_WRITE;
            ctl[j].wr  = wr_alloc;
          end else if (split && hit_lo[j]) begin
            ctl[j].cmd = CMD_WRITE;
            ctl[j].wr  = wr_split;
          end else if (split && after[j]) begin
            ctl[j].cmd = CMD_FROM_LEFT;
          end
        end else if (merge_prev) begin
          if (hit_hi[j]) begin
            ctl[j].cmd = CMD_WRITE;
            ctl[j].wr  = wr_prev;
          end else if (hit_q[j] || after[j]) begin
            ctl[j].cmd = merge_next ? CMD_FROM_RIGHT2 : CMD_FROM_RIGHT;
          end
        end else begin
          if (hit_q[j]) begin
            ctl[j].cmd = CMD_WRITE;
            ctl[j].wr  = wr_free;
          end else if (merge_next && after[j]) begin
            ctl[j].cmd = CMD_FROM_RIGHT;
          end
        end
      end
    end
  end

  // Sequencer and result register. A failed search answers straight from
  // the search state; a match passes through the update state to rewrite the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      status         <= ST_GRANTED;
      payload_offset <= '0;
      hit_q          <= '0;
      passed_q       <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q     <= op_t'(operation);
            req_q    <= request_size;
            passed_q <= '0;
            state    <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          passed_q <= passed_q | (tok_vec & ~hit_vec);
          if (any_hit) begin
            hit_q <= hit_vec;
            state <= S_UPDATE;
          end else if (any_stop) begin
            done           <= 1'b1;
            status         <= (op_q == OP_ALLOC) ? ST_NOFIT : ST_BADOFF;
            payload_offset <= '0;
            state          <= S_IDLE;
          end
        end
        S_UPDATE: begin
          done <= 1'b1;
          if (op_q == OP_ALLOC) begin
            status         <= ST_GRANTED;
            payload_offset <= ek.start + HDR;
          end else begin
            status         <= ST_FREED;
            payload_offset <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Exactly one token is in the row while searching, and none otherwise.
  a_token_count: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_vec) == ((state == S_SEARCH) ? 1 : 0))
    else $error("request token count does not match the search state");

  // A token can only end its walk in one place.
  a_single_end: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec | stop_vec))
    else $error("more than one cell ended the search");

  // Valid entries stay packed at the low end, and the first is never empty.
  a_packed_table: assert property (@(posedge clk) disable iff (rst)
    valid_vec[0] && ((valid_vec & (valid_vec + ONE_V)) == '0))
    else $error("table entries are not contiguous");

  // The rewrite cycle always follows a match found in the search.
  a_update_after_hit: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE |-> $onehot(hit_q) && $past(state == S_SEARCH))
    else $error("table rewrite without a single matching entry");
`endif

endmodule
